// ===== rtl/rpe_pkg.sv =====
// Shared types and constants of the Rademacher perturbation engine.
package rpe_pkg;

  localparam int unsigned CNT_W = 25;
  localparam logic [CNT_W-1:0] MAX_ELEMENTS = 25'd16777216;
  localparam logic [CNT_W-1:0] ELEMENT_COUNT_RESET = 25'd1;

  localparam logic [63:0] SM_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] SM_MUL1  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] SM_MUL2  = 64'h94D049BB133111EB;
  localparam int unsigned SM_SHIFT1 = 30;
  localparam int unsigned SM_SHIFT2 = 27;
  localparam int unsigned SM_SHIFT3 = 31;
  localparam int unsigned XO_SHIFT  = 17;
  localparam int unsigned XO_ROT    = 45;

  localparam logic KIND_SEED = 1'b0;

  localparam logic REG_ELEMENT_COUNT = 1'b0;
  localparam logic REG_STEP_SCALE    = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [63:0]       seed_word;
    logic signed [31:0] element_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] perturbed_value;
    logic               sign_plus;
    logic               saturated;
    logic               pass_end;
  } out_t;

  typedef enum logic {
    OP_SEED,
    OP_ELEM
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] operand;
  } cmd_t;

  typedef struct packed {
    logic        start;
    logic [63:0] seed;
  } seed_req_t;

  typedef struct packed {
    logic             done;
    logic [3:0][63:0] words;
  } seed_rsp_t;

  typedef enum logic {
    CORE_RUN,
    CORE_SEED
  } core_state_t;

  typedef enum logic [2:0] {
    SD_IDLE,
    SD_MIX1,
    SD_MUL1,
    SD_MIX2,
    SD_MUL2,
    SD_FIN
  } sd_state_t;

endpackage

// ===== rtl/rademacher_perturbation_engine.sv =====
// Top level of the Rademacher perturbation engine with its register file.
// Element requests run at one per clock cycle sustained while out_ready is high and
// no seed is pending: a two-entry request queue feeds the core, which draws xoshiro256+
// sign bits and applies the signed step combinationally, and results leave through an
// output register that holds while out_ready is low. Seeds go to the splitmix64 seeding
// unit, which forms each 64-bit product from 32x32 partial products on one multiplier
// (four rounds of two products each); elements queued behind a seed wait until it
// completes and seed requests give no result. Registers: element_count at byte address 0
// and step_scale at byte address 4; write them only while no request is in flight.
module rademacher_perturbation_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rpe_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rpe_pkg::out_t out_data,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);
  import rpe_pkg::*;

  logic [CNT_W-1:0]   element_count_r;
  logic signed [31:0] step_scale_r;
  logic               cfg_wr;
  logic               q_valid;
  logic               q_ready;
  cmd_t               q_cmd;
  seed_req_t          seed_req;
  seed_rsp_t          seed_rsp;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      element_count_r <= ELEMENT_COUNT_RESET;
      step_scale_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_ELEMENT_COUNT: element_count_r <= cfg_pwdata[CNT_W-1:0];
        REG_STEP_SCALE:    step_scale_r    <= cfg_pwdata;
        default:           step_scale_r    <= step_scale_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_ELEMENT_COUNT: cfg_prdata = {{(32 - CNT_W){1'b0}}, element_count_r};
      REG_STEP_SCALE:    cfg_prdata = step_scale_r;
      default:           cfg_prdata = '0;
    endcase
  end

  rpe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  rpe_seed u_seed (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (seed_req),
    .rsp   (seed_rsp)
  );

  rpe_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .element_count (element_count_r),
    .step_scale    (step_scale_r),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_cmd         (q_cmd),
    .seed_req      (seed_req),
    .seed_rsp      (seed_rsp),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

endmodule

// ===== rtl/rpe_front.sv =====
// Front end: accepts requests, classifies them and queues them for the core.
module rpe_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rpe_pkg::in_t  in_data,
  output logic          q_valid,
  input  logic          q_ready,
  output rpe_pkg::cmd_t q_cmd
);
  import rpe_pkg::*;

  cmd_t       entry_r [2];
  cmd_t       cmd_nxt;
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;

  always_comb begin
    if (in_data.kind == KIND_SEED) begin
      cmd_nxt.op      = OP_SEED;
      cmd_nxt.operand = in_data.seed_word;
    end else begin
      cmd_nxt.op      = OP_ELEM;
      cmd_nxt.operand = {32'd0, in_data.element_value};
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = entry_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/rpe_seed.sv =====
// Splitmix64 seeding unit built around one shared 32x32 multiplier.
module rpe_seed (
  input  logic               clk,
  input  logic               rst_n,
  input  rpe_pkg::seed_req_t req,
  output rpe_pkg::seed_rsp_t rsp
);
  import rpe_pkg::*;

  sd_state_t        state_r;
  sd_state_t        state_nxt;
  logic [63:0]      s_r;
  logic [63:0]      x_r;
  logic [63:0]      acc_r;
  logic [63:0]      prod_r;
  logic [1:0]       phase_r;
  logic [1:0]       round_r;
  logic             done_r;
  logic [3:0][63:0] words_r;
  logic [63:0]      mul_k;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      prod_nxt;
  logic [63:0]      z_add;

  assign mul_k    = (state_r == SD_MUL2) ? SM_MUL2 : SM_MUL1;
  assign z_add    = s_r + SM_GAMMA;
  assign prod_nxt = mul_a * mul_b;

  always_comb begin
    case (phase_r)
      2'd1: begin
        mul_a = x_r[63:32];
        mul_b = mul_k[31:0];
      end
      2'd2: begin
        mul_a = x_r[31:0];
        mul_b = mul_k[63:32];
      end
      default: begin
        mul_a = x_r[31:0];
        mul_b = mul_k[31:0];
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SD_IDLE: begin
        if (req.start) begin
          state_nxt = SD_MIX1;
        end
      end
      SD_MIX1: state_nxt = SD_MUL1;
      SD_MUL1: begin
        if (phase_r == 2'd3) begin
          state_nxt = SD_MIX2;
        end
      end
      SD_MIX2: state_nxt = SD_MUL2;
      SD_MUL2: begin
        if (phase_r == 2'd3) begin
          state_nxt = SD_FIN;
        end
      end
      SD_FIN: state_nxt = (round_r == 2'd3) ? SD_IDLE : SD_MIX1;
      default: state_nxt = SD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SD_IDLE;
      done_r  <= 1'b0;
      phase_r <= 2'd0;
      round_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == SD_FIN) && (round_r == 2'd3);
      if (state_r == SD_MUL1 || state_r == SD_MUL2) begin
        phase_r <= phase_r + 2'd1;
      end else begin
        phase_r <= 2'd0;
      end
      if (state_r == SD_IDLE) begin
        round_r <= 2'd0;
      end else if (state_r == SD_FIN) begin
        round_r <= round_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      SD_IDLE: begin
        if (req.start) begin
          s_r <= req.seed;
        end
      end
      SD_MIX1: begin
        s_r <= z_add;
        x_r <= z_add ^ (z_add >> SM_SHIFT1);
      end
      SD_MIX2: x_r <= acc_r ^ (acc_r >> SM_SHIFT2);
      SD_MUL1, SD_MUL2: begin
        prod_r <= prod_nxt;
        case (phase_r)
          2'd1:    acc_r <= prod_r;
          2'd2:    acc_r <= acc_r + {prod_r[31:0], 32'd0};
          2'd3:    acc_r <= acc_r + {prod_r[31:0], 32'd0};
          default: acc_r <= acc_r;
        endcase
      end
      SD_FIN: words_r[round_r] <= acc_r ^ (acc_r >> SM_SHIFT3);
      default: s_r <= s_r;
    endcase
  end

  assign rsp.done  = done_r;
  assign rsp.words = words_r;

endmodule

// ===== rtl/rpe_core.sv =====
// Back end: runs the xoshiro256+ generator and applies signed steps to elements.
module rpe_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rpe_pkg::CNT_W-1:0]   element_count,
  input  logic signed [31:0]          step_scale,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  rpe_pkg::cmd_t               q_cmd,
  output rpe_pkg::seed_req_t          seed_req,
  input  rpe_pkg::seed_rsp_t          seed_rsp,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rpe_pkg::out_t               out_data
);
  import rpe_pkg::*;

  core_state_t      state_r;
  core_state_t      state_nxt;
  logic [3:0][63:0] w_r;
  logic [3:0]       group_r;
  logic [CNT_W-1:0] index_r;
  logic             out_valid_r;
  out_t             out_data_r;

  logic             pop;
  logic             pop_elem;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] grouped;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_inc;
  logic             in_group;
  logic             grp_start;
  logic             do_draw;
  logic [3:0]       d4;
  logic             plus;
  logic             last;
  logic [32:0]      scale_ext;
  logic [32:0]      sum;
  logic [63:0]      sh;
  logic [63:0]      t2;
  logic [63:0]      t3;
  logic [3:0][63:0] w_step;
  out_t             res;

  always_comb begin
    if (element_count == '0) begin
      n_eff = ELEMENT_COUNT_RESET;
    end else if (element_count > MAX_ELEMENTS) begin
      n_eff = MAX_ELEMENTS;
    end else begin
      n_eff = element_count;
    end
  end

  assign grouped   = {n_eff[CNT_W-1:2], 2'b00};
  assign idx       = (index_r >= n_eff) ? '0 : index_r;
  assign idx_inc   = idx + CNT_W'(1);
  assign last      = (idx_inc == n_eff);
  assign in_group  = (idx < grouped);
  assign grp_start = in_group && (idx[1:0] == 2'b00);
  assign do_draw   = !in_group || grp_start;
  assign d4        = w_r[0][3:0] + w_r[3][3:0];
  assign plus      = (in_group && !grp_start) ? group_r[idx[1:0]] : d4[0];

  assign sh        = w_r[1] << XO_SHIFT;
  assign t2        = w_r[2] ^ w_r[0];
  assign t3        = w_r[3] ^ w_r[1];
  assign w_step[0] = w_r[0] ^ t3;
  assign w_step[1] = w_r[1] ^ t2;
  assign w_step[2] = t2 ^ sh;
  assign w_step[3] = (t3 << XO_ROT) | (t3 >> (64 - XO_ROT));

  assign scale_ext = plus ? {step_scale[31], step_scale}
                          : 33'd0 - {step_scale[31], step_scale};
  assign sum       = {q_cmd.operand[31], q_cmd.operand[31:0]} + scale_ext;

  always_comb begin
    res.sign_plus = plus;
    res.pass_end  = last;
    if (sum[32] != sum[31]) begin
      res.saturated       = 1'b1;
      res.perturbed_value = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      res.saturated       = 1'b0;
      res.perturbed_value = sum[31:0];
    end
  end

  always_comb begin
    q_ready   = 1'b0;
    state_nxt = state_r;
    case (state_r)
      CORE_RUN: begin
        q_ready = (q_cmd.op == OP_SEED) || !out_valid_r || out_ready;
        if (q_valid && q_cmd.op == OP_SEED) begin
          state_nxt = CORE_SEED;
        end
      end
      CORE_SEED: begin
        if (seed_rsp.done) begin
          state_nxt = CORE_RUN;
        end
      end
      default: state_nxt = CORE_RUN;
    endcase
  end

  assign pop            = q_valid && q_ready;
  assign pop_elem       = pop && (q_cmd.op == OP_ELEM);
  assign seed_req.start = pop && (q_cmd.op == OP_SEED);
  assign seed_req.seed  = q_cmd.operand;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CORE_RUN;
      w_r         <= '0;
      group_r     <= '0;
      index_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == CORE_SEED && seed_rsp.done) begin
        w_r     <= seed_rsp.words;
        group_r <= '0;
        index_r <= '0;
      end else if (pop_elem) begin
        if (do_draw) begin
          w_r <= w_step;
        end
        if (grp_start) begin
          group_r <= d4;
        end
        index_r <= last ? '0 : idx_inc;
      end
      if (pop_elem) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_elem) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_pop_while_seeding: assert property (
    @(posedge clk) disable iff (!rst_n) (state_r == CORE_SEED) |-> !q_ready
  ) else $error("core popped a request while seeding");

  a_seed_done_expected: assert property (
    @(posedge clk) disable iff (!rst_n) seed_rsp.done |-> (state_r == CORE_SEED)
  ) else $error("seed unit finished without a pending seed");

  a_no_result_overwrite: assert property (
    @(posedge clk) disable iff (!rst_n) (out_valid_r && !out_ready) |-> !pop_elem
  ) else $error("element popped over an untaken result");

  a_index_in_range: assert property (
    @(posedge clk) disable iff (!rst_n) pop_elem |=> (index_r <= MAX_ELEMENTS)
  ) else $error("element index out of range");

endmodule

// ===== tb/tb_rademacher_perturbation_engine.sv =====
// Self-checking testbench for the Rademacher perturbation engine.
`timescale 1ns / 100ps

module tb_rademacher_perturbation_engine;
  import rpe_pkg::*;

  localparam logic KIND_ELEM = 1'b1;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned DRAIN_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int fail_count = 0;

  logic [63:0] xo_word [4] = '{default: '0};
  logic [3:0] sign_group = '0;
  logic [24:0] pass_pos = '0;
  logic [24:0] count_reg = ELEMENT_COUNT_RESET;
  logic [31:0] scale_reg = '0;
  out_t pending_results[$];

  rademacher_perturbation_engine dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] xoshiro_draw();
    logic [63:0] res;
    logic [63:0] sh;
    res = xo_word[0] + xo_word[3];
    sh = xo_word[1] << XO_SHIFT;
    xo_word[2] = xo_word[2] ^ xo_word[0];
    xo_word[3] = xo_word[3] ^ xo_word[1];
    xo_word[1] = xo_word[1] ^ xo_word[2];
    xo_word[0] = xo_word[0] ^ xo_word[3];
    xo_word[2] = xo_word[2] ^ sh;
    xo_word[3] = {xo_word[3][63-XO_ROT:0], xo_word[3][63:64-XO_ROT]};
    return res;
  endfunction

  function automatic void splitmix_fill(logic [63:0] seed);
    logic [63:0] s;
    logic [63:0] z;
    s = seed;
    for (int r = 0; r < 4; r++) begin
      s = s + SM_GAMMA;
      z = (s ^ (s >> SM_SHIFT1)) * SM_MUL1;
      z = (z ^ (z >> SM_SHIFT2)) * SM_MUL2;
      xo_word[r] = z ^ (z >> SM_SHIFT3);
    end
  endfunction

  function automatic void predict_perturbation(in_t req);
    logic [24:0] n;
    logic [24:0] grouped;
    logic [24:0] idx;
    logic [63:0] draw;
    logic sign_bit;
    logic pass_last;
    longint total;
    out_t res;
    if (req.kind == KIND_SEED) begin
      splitmix_fill(req.seed_word);
      pass_pos = '0;
      sign_group = '0;
      return;
    end
    n = count_reg;
    if (n == 25'd0) n = 25'd1;
    if (n > MAX_ELEMENTS) n = MAX_ELEMENTS;
    grouped = n & ~25'd3;
    idx = (pass_pos >= n) ? 25'd0 : pass_pos;
    if (idx < grouped) begin
      if (idx[1:0] == 2'd0) begin
        draw = xoshiro_draw();
        sign_group = draw[3:0];
      end
      sign_bit = sign_group[idx[1:0]];
    end else begin
      draw = xoshiro_draw();
      sign_bit = draw[0];
    end
    total = longint'($signed(req.element_value)) +
            (sign_bit ? longint'($signed(scale_reg)) : -longint'($signed(scale_reg)));
    res.saturated = 1'b0;
    if (total > longint'(32'sh7FFF_FFFF)) begin
      total = longint'(32'sh7FFF_FFFF);
      res.saturated = 1'b1;
    end else if (total < -longint'(64'h8000_0000)) begin
      total = -longint'(64'h8000_0000);
      res.saturated = 1'b1;
    end
    pass_last = (idx + 25'd1 == n);
    pass_pos = pass_last ? 25'd0 : idx + 25'd1;
    res.perturbed_value = 32'(total);
    res.sign_plus = sign_bit;
    res.pass_end = pass_last;
    pending_results.push_back(res);
  endfunction

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: %p", out_data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.perturbed_value !== want.perturbed_value) begin
          $error("perturbed_value: expected %0d, got %0d",
                 $signed(want.perturbed_value), $signed(out_data.perturbed_value));
          fail_count++;
        end
        if (out_data.sign_plus !== want.sign_plus) begin
          $error("sign_plus: expected %0b, got %0b", want.sign_plus, out_data.sign_plus);
          fail_count++;
        end
        if (out_data.saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, out_data.saturated);
          fail_count++;
        end
        if (out_data.pass_end !== want.pass_end) begin
          $error("pass_end: expected %0b, got %0b", want.pass_end, out_data.pass_end);
          fail_count++;
        end
      end
    end
  end

  task automatic send_request(in_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    predict_perturbation(req);
  endtask

  task automatic send_element(logic [31:0] value);
    in_t req;
    req.kind = KIND_ELEM;
    req.seed_word = {$urandom, $urandom};
    req.element_value = value;
    send_request(req);
  endtask

  task automatic send_seed(logic [63:0] seed);
    in_t req;
    req.kind = KIND_SEED;
    req.seed_word = seed;
    req.element_value = $urandom;
    send_request(req);
  endtask

  task automatic settle();
    int waited;
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
      pending_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic reg_idx, logic [31:0] value);
    logic [31:0] readback;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {reg_idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (reg_idx == REG_ELEMENT_COUNT) begin
      count_reg = value[CNT_W-1:0];
      readback = {7'd0, count_reg};
    end else begin
      scale_reg = value;
      readback = value;
    end
    @(negedge clk);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== readback) begin
      $error("register %0d readback: expected %h, got %h", reg_idx, readback, cfg_prdata);
      fail_count++;
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic configure(logic [31:0] count, logic [31:0] scale);
    settle();
    write_register(REG_ELEMENT_COUNT, count);
    write_register(REG_STEP_SCALE, scale);
  endtask

  function automatic logic [31:0] pick_count();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return $urandom_range(13, 40);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    logic [31:0] mag;
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: begin
        mag = $urandom_range(0, 32'h0003_FFFF);
        return $urandom_range(1) ? -mag : mag;
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_unseeded_draws();
    send_element(32'h7FFF_FFFF);
    send_element(32'h8000_0000);
    send_element($urandom);
  endtask

  task automatic test_saturation_edges();
    configure(32'd4, 32'h7FFF_FFFF);
    send_seed('1);
    send_element(32'h7FFF_FFFF);
    send_element(32'h8000_0000);
    send_element(32'hFFFF_FFFF);
    configure(32'd4, 32'h8000_0000);
    send_element(32'h7FFF_FFFF);
    send_element(32'h8000_0000);
    send_element(32'h0000_0000);
  endtask

  task automatic test_group_and_tail();
    configure(32'd5, 32'h0001_0000);
    send_seed('0);
    for (int i = 0; i < 6; i++) send_element($urandom);
  endtask

  task automatic test_count_lowered();
    configure(32'd8, 32'h0000_8000);
    for (int i = 0; i < 4; i++) send_element($urandom);
    configure(32'd3, 32'hFFFF_8000);
    send_element($urandom);
    send_element($urandom);
  endtask

  task automatic test_count_limits();
    configure(32'd0, $urandom);
    send_element(pick_value());
    send_element(pick_value());
    configure(32'h01FF_FFFF, $urandom);
    send_element(pick_value());
    send_element(pick_value());
  endtask

  task automatic run_random_phase(int send_pct, int recv_pct, int items);
    in_t req;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    configure(pick_count(), pick_scale());
    for (int i = 0; i < items; i++) begin
      if (i % 30 == 29) configure(pick_count(), pick_scale());
      req.kind = ($urandom_range(15) == 0) ? KIND_SEED : KIND_ELEM;
      req.seed_word = {$urandom, $urandom};
      req.element_value = pick_value();
      send_request(req);
    end
    settle();
  endtask

  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    configure(32'd7, 32'h0000_4000);
    send_seed({$urandom, $urandom});
    hold_cycles = 300;
    for (int i = 0; i < 40; i++) send_element(pick_value());
    settle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_unseeded_draws();
    test_saturation_edges();
    test_group_and_tail();
    test_count_lowered();
    test_count_limits();
    run_random_phase(0, 0, 90);
    run_random_phase(55, 0, 90);
    run_random_phase(0, 55, 90);
    run_random_phase(19, 19, 90);
    test_output_hold_off();
    settle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
